>>> rtl/core/frame_rate_median_meter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame rate median meter
// Concurrent assertion helpers, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef FRAME_RATE_MEDIAN_METER_ASSERT_SVH
`define FRAME_RATE_MEDIAN_METER_ASSERT_SVH
`ifndef ASSERT_OFF
`define FRMM_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define FRMM_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define FRMM_ASSERT_IMPL(label, clk, rst_n, prop)
`define FRMM_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> rtl/core/frmm_pkg.sv
// ----------------------------------------------------------------------------
// frmm_pkg
// Shared types and constants of the frame rate median meter.
// ----------------------------------------------------------------------------
package frmm_pkg;
    localparam int WINDOW    = 31;
    localparam int IDX_W     = 5;
    localparam logic [13:0] FPS_LIMIT = 14'd9999;
    localparam logic [31:0] TPS_RESET = 32'd1000000000;
    localparam logic [63:0] REFRESH_RESET = 64'd250000000;
    // register byte addresses, 8 bytes apart on the 64-bit bus
    localparam logic [3:0] ADDR_TPS = 4'd0;
    localparam logic [3:0] ADDR_REFRESH = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } div_rsp_t;
endpackage

>>> rtl/core/frmm_divider.sv
// ----------------------------------------------------------------------------
// frmm_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frmm_divider
(
    input  logic                clk,
    input  logic                rst_n,
    input  frmm_pkg::div_req_t  req,
    output frmm_pkg::div_rsp_t  rsp
);
    logic [63:0] quot_reg, quot_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[63:0], quot_reg[63]};
        if (req.start)
        begin
            quot_next = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
endmodule

>>> rtl/core/frmm_ring_ram.sv
// ----------------------------------------------------------------------------
// frmm_ring_ram
// Interval ring, one write port and one registered read port.
// ----------------------------------------------------------------------------
module frmm_ring_ram
(
    input  logic        clk,
    input  logic        we,
    input  logic [4:0]  waddr,
    input  logic [31:0] wdata,
    input  logic [4:0]  raddr,
    output logic [31:0] rdata
);
    logic [31:0] mem [frmm_pkg::WINDOW];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/core/frame_rate_median_meter.sv
// ----------------------------------------------------------------------------
// frame_rate_median_meter
// Sliding-window median interval and rounded frame rate from timestamps.
// ----------------------------------------------------------------------------
// One timestamp per frame transaction. Each event after the first stores its
// interval into a 31-entry ring RAM; when the elapsed ticks reach
// refresh_ticks a readout is made. The upper median is found by a rank count:
// for each candidate i, all n entries are streamed from the single RAM read
// port, and the search stops at the first candidate of matching rank. The
// rate then goes through a bit-serial divider. An event without a readout
// passes through the write state back to idle; one with a readout goes on
// through the scan, divide and output states.
// A finished readout waits in the output register; a second readout that
// finds it still occupied waits in the output state until it has gone. The
// input is stalled in every state but idle.
module frame_rate_median_meter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] timestamp
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [13:0] fps, [45:14] median, [50:46] samples
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
`include "frame_rate_median_meter_assert.svh"

    frmm_pkg::state_t state_reg, state_next;
    logic [31:0] tps_reg;
    logic [63:0] refresh_reg;
    logic [63:0] prev_reg;
    logic        havep_reg;
    logic        havep_d_reg;      // event in the write state had a previous stamp
    logic [63:0] acc_reg;
    logic [4:0]  slot_reg, fill_reg;
    logic [31:0] delta_reg;
    logic [63:0] delta_full_reg;
    logic [4:0]  ci_reg, cj_reg;   // candidate index, streamed index
    logic [5:0]  rd_cnt_reg;       // read beat counter, including the registered RAM read
    logic [31:0] cand_reg;
    logic [4:0]  below_reg, same_reg;
    logic [31:0] med_reg;
    logic [55:0] out_reg;
    logic        oval_reg;

    logic        wr_cyc;
    logic [4:0]  raddr;
    logic [31:0] rdata;
    frmm_pkg::div_req_t dreq;
    frmm_pkg::div_rsp_t drsp;
    logic        s_acc, cfg_wr;
    logic [63:0] delta_full;
    logic [64:0] acc_sum;
    logic        readout;
    logic [4:0]  rank;
    logic        below_hit, same_hit;
    logic [4:0]  below_fin;
    logic [5:0]  bs_fin;
    logic        last_beat, found;
    logic        load_out;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    always_comb
    begin
        unique case (paddr)
            frmm_pkg::ADDR_TPS:     prdata = {32'd0, tps_reg};
            frmm_pkg::ADDR_REFRESH: prdata = refresh_reg;
            default:                prdata = '0;
        endcase
    end

    assign s_tready = (state_reg == frmm_pkg::ST_IDLE);
    assign s_acc    = s_tvalid & s_tready;
    assign delta_full = s_tdata - prev_reg;
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, delta_full_reg};
    assign readout  = havep_d_reg && (acc_sum >= {1'b0, refresh_reg});
    assign rank = fill_reg >> 1;

    // the last streamed entry is counted in the same cycle as the decision
    assign below_hit = (rdata < cand_reg);
    assign same_hit  = (rdata == cand_reg);
    assign below_fin = below_reg + {4'd0, below_hit};
    assign bs_fin    = {1'b0, below_fin} + {1'b0, same_reg} + {5'd0, same_hit};
    assign last_beat = (rd_cnt_reg == {1'b0, fill_reg} + 6'd1);
    assign found     = last_beat && (below_fin <= rank) && ({1'b0, rank} < bs_fin);

    assign wr_cyc = (state_reg == frmm_pkg::ST_WRITE) & havep_d_reg;
    assign raddr = cj_reg;

    frmm_ring_ram u_ram
    (
        .clk   (clk),
        .we    (wr_cyc),
        .waddr (slot_reg),
        .wdata (delta_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    frmm_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            frmm_pkg::ST_IDLE:  if (s_acc) state_next = frmm_pkg::ST_WRITE;
            frmm_pkg::ST_WRITE:
            begin
                if (readout)
                    state_next = frmm_pkg::ST_SCAN;
                else
                    state_next = frmm_pkg::ST_IDLE;
            end
            frmm_pkg::ST_SCAN:  if (found) state_next = frmm_pkg::ST_DIV;
            frmm_pkg::ST_DIV:   if (drsp.done) state_next = frmm_pkg::ST_OUT;
            frmm_pkg::ST_OUT:   if (!oval_reg || m_tready) state_next = frmm_pkg::ST_IDLE;
            default:            state_next = frmm_pkg::ST_IDLE;
        endcase
    end

    // divider launch and output load
    always_comb
    begin
        dreq.start = (state_reg == frmm_pkg::ST_SCAN) && found;
        dreq.num   = {31'd0, tps_reg, 1'b0} + {32'd0, cand_reg};
        dreq.den   = {31'd0, cand_reg, 1'b0};
        load_out   = (state_reg == frmm_pkg::ST_OUT) && (!oval_reg || m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= frmm_pkg::ST_IDLE;
            tps_reg     <= frmm_pkg::TPS_RESET;
            refresh_reg <= frmm_pkg::REFRESH_RESET;
            prev_reg    <= '0;
            havep_reg   <= 1'b0;
            havep_d_reg <= 1'b0;
            acc_reg     <= '0;
            slot_reg    <= '0;
            fill_reg    <= '0;
            oval_reg    <= 1'b0;
            ci_reg      <= '0;
            cj_reg      <= '0;
            rd_cnt_reg  <= '0;
            below_reg   <= '0;
            same_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                unique case (paddr)
                    frmm_pkg::ADDR_TPS:     tps_reg <= pwdata[31:0];
                    frmm_pkg::ADDR_REFRESH: refresh_reg <= pwdata;
                    default: ;
                endcase
            end
            if (load_out)
                oval_reg <= 1'b1;
            else if (oval_reg && m_tready)
                oval_reg <= 1'b0;
            if (s_acc)
            begin
                havep_d_reg <= havep_reg;
                havep_reg   <= 1'b1;
                prev_reg    <= s_tdata;
            end
            if (state_reg == frmm_pkg::ST_WRITE && havep_d_reg)
            begin
                slot_reg <= (slot_reg == 5'(frmm_pkg::WINDOW - 1)) ? 5'd0 : slot_reg + 5'd1;
                if (fill_reg != 5'(frmm_pkg::WINDOW))
                    fill_reg <= fill_reg + 5'd1;
                if (readout)
                begin
                    acc_reg    <= '0;
                    ci_reg     <= '0;
                    cj_reg     <= '0;
                    rd_cnt_reg <= '0;
                    below_reg  <= '0;
                    same_reg   <= '0;
                end
                else
                    acc_reg <= acc_sum[64] ? 64'hFFFFFFFFFFFFFFFF : acc_sum[63:0];
            end
            if (state_reg == frmm_pkg::ST_SCAN)
            begin
                // first beat fetches the candidate itself
                if (rd_cnt_reg == 6'd0)
                begin
                    cj_reg     <= '0;
                    rd_cnt_reg <= 6'd1;
                end
                else if (last_beat)
                begin
                    ci_reg     <= ci_reg + 5'd1;
                    cj_reg     <= ci_reg + 5'd1;
                    rd_cnt_reg <= '0;
                    below_reg  <= '0;
                    same_reg   <= '0;
                end
                else
                begin
                    if (rd_cnt_reg != {1'b0, fill_reg})
                        cj_reg <= cj_reg + 5'd1;
                    rd_cnt_reg <= rd_cnt_reg + 6'd1;
                    if (rd_cnt_reg != 6'd1)
                    begin
                        if (below_hit)     below_reg <= below_reg + 5'd1;
                        else if (same_hit) same_reg  <= same_reg + 5'd1;
                    end
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            delta_reg      <= (|delta_full[63:32]) ? 32'hFFFFFFFF : delta_full[31:0];
            delta_full_reg <= delta_full;
        end
        if (state_reg == frmm_pkg::ST_SCAN && rd_cnt_reg == 6'd1)
            cand_reg <= rdata;
        if (dreq.start)
            med_reg <= cand_reg;
        // divider quotient holds until the next launch
        if (load_out)
        begin
            out_reg[13:0]  <= (med_reg == 32'd0) ? 14'd0 :
                              (drsp.quot > 64'(frmm_pkg::FPS_LIMIT)) ?
                              frmm_pkg::FPS_LIMIT : drsp.quot[13:0];
            out_reg[45:14] <= med_reg;
            out_reg[50:46] <= fill_reg;
            out_reg[55:51] <= '0;
        end
    end

    assign m_tvalid = oval_reg;
    assign m_tdata  = out_reg;

    `FRMM_NEVER(a_scan_in_fill, clk, rst_n, state_reg == frmm_pkg::ST_SCAN && ci_reg >= fill_reg)
    `FRMM_ASSERT_IMPL(a_fill_max, clk, rst_n, fill_reg <= 5'(frmm_pkg::WINDOW))
    `FRMM_ASSERT_IMPL(a_out_after_div, clk, rst_n, $rose(oval_reg) |-> $past(state_reg == frmm_pkg::ST_OUT))
endmodule

>>> tb/frame_rate_median_meter_test.sv
// ----------------------------------------------------------------------------
// frame_rate_median_meter_test
// Drives timestamp transactions into the meter, predicts each readout from a
// behavioural copy of the interval ring and compares every output field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_rate_median_meter_test;

    localparam int         WATCHDOG_LIMIT  = 40000;
    localparam int         LONG_HOLD       = 5000;

    typedef struct {
        logic [13:0] fps;
        logic [31:0] median;
        logic [4:0]  samples;
    } readout_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;      // [63:0] timestamp
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;           // [13:0] fps, [45:14] median, [50:46] samples
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    frame_rate_median_meter u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // ---- predictor state: mirror of the meter's own state and registers ----
    logic [31:0] ring_model [frmm_pkg::WINDOW];
    int          slot_model;
    int          fill_model;
    logic [63:0] last_stamp;
    logic        have_stamp;
    logic [63:0] elapsed_ticks;
    logic [31:0] rate_reg;
    logic [63:0] refresh_reg;

    logic [63:0] stamp_queue [$];   // timestamps waiting to be offered
    readout_t    readouts_due [$];  // predicted readouts, oldest first
    int          error_count = 0;
    bit          idling_on = 1'b0;
    int          results_seen = 0;

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Upper median (rank fill/2, ascending) and rounded rate of the window
    task automatic predict_stamp(input logic [63:0] now);
        logic [63:0] gap;
        logic [31:0] sorted_iv [$];
        logic [31:0] med;
        logic [63:0] quot;
        readout_t    r;
        if (have_stamp)
        begin
            gap = now - last_stamp;
            ring_model[slot_model] = (gap > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : gap[31:0];
            slot_model = (slot_model + 1) % frmm_pkg::WINDOW;
            if (fill_model < frmm_pkg::WINDOW)
                fill_model++;
            // accumulator saturates rather than wraps
            if (elapsed_ticks > ~gap)
                elapsed_ticks = '1;
            else
                elapsed_ticks = elapsed_ticks + gap;
        end
        last_stamp = now;
        have_stamp = 1'b1;
        if (fill_model == 0 || elapsed_ticks < refresh_reg)
            return;
        elapsed_ticks = '0;
        for (int i = 0; i < fill_model; i++)
            sorted_iv.push_back(ring_model[i]);
        sorted_iv.sort();
        med = sorted_iv[fill_model / 2];
        if (med == 0)
            quot = 0;
        else
        begin
            quot = (2 * {32'd0, rate_reg} + {32'd0, med}) / (2 * {32'd0, med});
            if (quot > frmm_pkg::FPS_LIMIT)
                quot = 64'(frmm_pkg::FPS_LIMIT);
        end
        r.fps = quot[13:0];
        r.median = med;
        r.samples = fill_model[4:0];
        readouts_due.push_back(r);
    endtask

    // ---- timestamp driver ----
    int gap_left = 0;
    always @(posedge clk)
    begin
        logic        nv;
        logic [63:0] nd;
        nv = s_tvalid;
        nd = s_tdata;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_stamp(s_tdata);
                nv = 1'b0;
                gap_left = idling_on ? $urandom_range(0, 18) : 0;
            end
            if (!nv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (stamp_queue.size() > 0)
                begin
                    nd = stamp_queue.pop_front();
                    nv = 1'b1;
                end
            end
        end
        s_tvalid <= nv;
        s_tdata  <= nd;
    end

    // ---- readout monitor ----
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge clk)
    begin
        readout_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (readouts_due.size() == 0)
                report("unexpected readout", m_tdata, 0);
            else
            begin
                w = readouts_due.pop_front();
                if (m_tdata[13:0] != w.fps)
                    report("frames_per_second", m_tdata[13:0], w.fps);
                if (m_tdata[45:14] != w.median)
                    report("median_ticks", m_tdata[45:14], w.median);
                if (m_tdata[50:46] != w.samples)
                    report("samples_used", m_tdata[50:46], w.samples);
            end
            stall_left = idling_on ? $urandom_range(0, 18) : 0;
            // one long hold-off so the output register backs up into the input
            if (!hold_done && results_seen == 12)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= rst_n;
    end

    // ---- watchdog: cycles with no transaction on any port ----
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("frame_rate_median_meter_test: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic bus_write(input logic [3:0] a, input logic [63:0] d);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_rate(input logic [31:0] tps);
        bus_write(frmm_pkg::ADDR_TPS, {32'd0, tps});
        rate_reg = tps;
    endtask

    task automatic set_refresh(input logic [63:0] ticks);
        bus_write(frmm_pkg::ADDR_REFRESH, ticks);
        refresh_reg = ticks;
    endtask

    // Sender pauses until every readout is out, then lets an event with no
    // readout settle before the registers are touched.
    task automatic drain;
        @(posedge clk);
        while (stamp_queue.size() > 0 || s_tvalid || readouts_due.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    logic [63:0] stamp_now;
    task automatic push_gap(input logic [63:0] g);
        stamp_now = stamp_now + g;
        stamp_queue.push_back(stamp_now);
    endtask

    function automatic logic [63:0] random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return 64'd0;
        else if (pick < 80)
            return 64'($urandom_range(50, 8000));
        else if (pick < 95)
            return {32'd0, $urandom()};
        else
            return {$urandom(), $urandom()};
    endfunction

    initial
    begin
        for (int i = 0; i < frmm_pkg::WINDOW; i++)
            ring_model[i] = '0;
        slot_model = 0; fill_model = 0; last_stamp = '0; have_stamp = 1'b0;
        elapsed_ticks = '0;
        rate_reg = frmm_pkg::TPS_RESET;
        refresh_reg = frmm_pkg::REFRESH_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset registers: first event at zero, two readouts, zero gap
        stamp_now = '0;
        stamp_queue.push_back(stamp_now);
        push_gap(64'd250_000_000);
        push_gap(64'd0);
        push_gap(64'd300_000_000);
        drain();

        // Every event reads out; rate clamps high, then zero medians, then wrap
        set_rate(32'hFFFF_FFFF);
        set_refresh(64'd0);
        push_gap(64'd1);
        repeat (5) push_gap(64'd0);
        stamp_now = 64'hFFFF_FFFF_FFFF_FFFB;
        stamp_queue.push_back(stamp_now);
        push_gap(64'd15);
        push_gap(64'h0000_0100_0000_0000);
        drain();

        // Accumulator saturation against the largest refresh, slowest clock
        set_rate(32'd1);
        set_refresh(64'hFFFF_FFFF_FFFF_FFFF);
        push_gap(64'h8000_0000_0000_0000);
        push_gap(64'h8000_0000_0000_0000);
        push_gap(64'h8000_0000_0000_0000);
        push_gap(64'd7);
        drain();

        set_refresh(64'd1);
        push_gap(64'd3);
        push_gap(64'd2);
        drain();

        // Random phases, idling alternates between phases
        for (int ph = 0; ph < 6; ph++)
        begin
            idling_on = (ph % 2 == 0);
            case (ph)
                0: set_rate(32'd1000);
                1: set_rate(32'hFFFF_FFFF);
                2: set_rate(32'd1);
                default: set_rate($urandom());
            endcase
            if (ph == 3)
                set_refresh(64'd0);
            else
                set_refresh(64'($urandom_range(1, 60000)));
            for (int k = 0; k < 85; k++)
            begin
                if ($urandom_range(0, 40) == 0)
                begin
                    stamp_now = {$urandom(), $urandom()};
                    stamp_queue.push_back(stamp_now);
                end
                else
                    push_gap(random_gap());
            end
            drain();
        end

        repeat (1200) @(posedge clk);
        while (readouts_due.size() > 0)
        begin
            report("missing readout", 0, readouts_due[0].median);
            void'(readouts_due.pop_front());
        end
        if (error_count == 0)
            $display("frame_rate_median_meter_test: clean");
        else
            $display("frame_rate_median_meter_test: errors");
        $finish;
    end
endmodule
